// File: rtl/npq_pkg.sv
package npq_pkg;

  localparam int NODE_W = 6;
  localparam int CNT_W  = 7;
  localparam int MODE_W = 4;
  localparam int STAT_W = 2;
  localparam int TAG_W  = 2;

  // most nodes that the clearing pass after reset places on the free list
  localparam int MAX_INIT = 64;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  // request modes
  localparam logic [MODE_W-1:0] MODE_INIT         = 4'd0;
  localparam logic [MODE_W-1:0] MODE_TAKE_FREE    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_PUT_FREE     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_PUT_TRAIN    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_TAKE_TRAIN   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY_TRAIN  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_PUT_TRACK    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_TAKE_TRACK   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_QUERY_TRACK  = 4'd8;
  localparam logic [MODE_W-1:0] MODE_REMOVE_TRACK = 4'd9;

  // list tags, also the index of each list's head, tail and count
  localparam logic [TAG_W-1:0] TAG_FREE  = 2'd0;
  localparam logic [TAG_W-1:0] TAG_TRAIN = 2'd1;
  localparam logic [TAG_W-1:0] TAG_TRACK = 2'd2;
  localparam logic [TAG_W-1:0] TAG_NONE  = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  // field write enables of the link memory
  typedef struct packed {
    logic nxt;
    logic prv;
    logic tag;
  } npq_wen_t;

endpackage

// File: rtl/npq_link_ram.sv
module npq_link_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  npq_pkg::npq_wen_t        wen_i,
  input  logic [AW-1:0]            wr_next_i,
  input  logic [AW-1:0]            wr_prev_i,
  input  logic [npq_pkg::TAG_W-1:0] wr_tag_i,
  output logic [AW-1:0]            rd_next_o,
  output logic [AW-1:0]            rd_prev_o,
  output logic [npq_pkg::TAG_W-1:0] rd_tag_o
);
  import npq_pkg::*;

  localparam int WW = 2 * AW + TAG_W;

  // word layout: tag, prev, next
  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wen_i.nxt) begin
      mem[wr_addr_i][AW-1:0] <= wr_next_i;
    end
    if (wen_i.prv) begin
      mem[wr_addr_i][2*AW-1:AW] <= wr_prev_i;
    end
    if (wen_i.tag) begin
      mem[wr_addr_i][WW-1:2*AW] <= wr_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_next_o = rd_q[AW-1:0];
  assign rd_prev_o = rd_q[2*AW-1:AW];
  assign rd_tag_o  = rd_q[WW-1:2*AW];

endmodule

// File: rtl/npq_seq.sv
module npq_seq #(
  parameter int POOL_NODES = 64,
  parameter int IW         = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [npq_pkg::MODE_W-1:0] mode_i,
  input  logic [npq_pkg::NODE_W-1:0] node_i,
  input  logic [npq_pkg::CNT_W-1:0]  node_count_i,
  output logic                       done_o,
  output logic [npq_pkg::NODE_W-1:0] node_out_o,
  output logic [npq_pkg::STAT_W-1:0] status_o,
  output logic [npq_pkg::CNT_W-1:0]  free_count_o,
  output logic [npq_pkg::CNT_W-1:0]  train_count_o,
  output logic [npq_pkg::CNT_W-1:0]  track_count_o,
  output logic                       rd_en_o,
  output logic [IW-1:0]              rd_addr_o,
  input  logic [IW-1:0]              rd_next_i,
  input  logic [IW-1:0]              rd_prev_i,
  input  logic [npq_pkg::TAG_W-1:0]  rd_tag_i,
  output logic [IW-1:0]              wr_addr_o,
  output npq_pkg::npq_wen_t          wen_o,
  output logic [IW-1:0]              wr_next_o,
  output logic [IW-1:0]              wr_prev_o,
  output logic [npq_pkg::TAG_W-1:0]  wr_tag_o
);
  import npq_pkg::*;

  localparam int XW = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
  localparam int VW = (IW + 1 > NODE_W) ? IW + 1 : NODE_W;
  localparam logic [IW:0]       POOL_X = (IW + 1)'(POOL_NODES);
  localparam logic [IW-1:0]     LAST   = IW'(POOL_NODES - 1);
  localparam int                RST_NI = (POOL_NODES < MAX_INIT) ? POOL_NODES : MAX_INIT;
  localparam logic [CNT_W-1:0]  RST_N  = CNT_W'(RST_NI);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_EVAL,
    S_WR_PREV,
    S_WR_CLR,
    S_WR_ND
  } state_e;

  state_e              state_q;
  logic [IW-1:0]       sweep_q;
  logic [CNT_W-1:0]    n_q;
  logic                init_op_q;
  logic [MODE_W-1:0]   op_q;
  logic [IW-1:0]       nd_q;
  logic [TAG_W-1:0]    lst_q;
  logic [IW-1:0]       p_q;
  logic [IW-1:0]       q_q;
  logic                pw_q;
  logic                done_q;
  logic [NODE_W-1:0]   node_out_q;
  logic [STAT_W-1:0]   status_q;
  logic [IW-1:0]       heads_q [3];
  logic [IW-1:0]       tails_q [3];
  logic [CNT_W-1:0]    counts_q [3];

  logic                accept;
  logic [TAG_W-1:0]    req_lst;
  logic                req_take;
  logic                node_ok;
  logic [CNT_W-1:0]    n_eff;
  logic [IW-1:0]       head_sel;
  logic                take_empty;
  logic                op_take;
  logic                do_unlink;
  logic                h_hit;
  logic                t_hit;
  logic [CNT_W-1:0]    cnt_cur;
  logic [CNT_W-1:0]    cnt_dec;
  logic [XW-1:0]       ix;
  logic [XW-1:0]       nx;

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);
  assign node_ok = VW'(node_i) < VW'(POOL_NODES);
  assign n_eff   = (32'(node_count_i) > POOL_NODES) ? CNT_W'(POOL_NODES) : node_count_i;

  // list and kind of the incoming request
  always_comb begin
    req_lst  = TAG_FREE;
    req_take = 1'b0;
    unique case (mode_i) inside
      MODE_TAKE_FREE:                                 req_take = 1'b1;
      MODE_PUT_FREE:                                  req_lst = TAG_FREE;
      MODE_TAKE_TRAIN:                                begin
        req_lst  = TAG_TRAIN;
        req_take = 1'b1;
      end
      MODE_PUT_TRAIN, MODE_QUERY_TRAIN:               req_lst = TAG_TRAIN;
      MODE_TAKE_TRACK:                                begin
        req_lst  = TAG_TRACK;
        req_take = 1'b1;
      end
      MODE_PUT_TRACK, MODE_QUERY_TRACK, MODE_REMOVE_TRACK: req_lst = TAG_TRACK;
      default:                                        req_lst = TAG_FREE;
    endcase
  end

  assign head_sel   = heads_q[req_lst];
  assign take_empty = (counts_q[req_lst] == '0) || !({1'b0, head_sel} < POOL_X);
  assign rd_en_o    = accept;
  assign rd_addr_o  = req_take ? head_sel : IW'(node_i);

  // evaluation of the entry read for the held request
  assign op_take   = (op_q == MODE_TAKE_FREE) || (op_q == MODE_TAKE_TRAIN) ||
                     (op_q == MODE_TAKE_TRACK);
  assign do_unlink = op_take || ((op_q == MODE_REMOVE_TRACK) && (rd_tag_i == TAG_TRACK));
  assign h_hit     = (heads_q[lst_q] == nd_q);
  assign t_hit     = (tails_q[lst_q] == nd_q);
  assign cnt_cur   = counts_q[lst_q];
  assign cnt_dec   = (cnt_cur != '0) ? cnt_cur - 1'b1 : cnt_cur;

  assign ix = XW'(sweep_q);
  assign nx = XW'(n_q);

  // link memory write port
  always_comb begin
    wr_addr_o = '0;
    wr_next_o = '0;
    wr_prev_o = '0;
    wr_tag_o  = TAG_NONE;
    wen_o     = '0;
    unique case (state_q)
      S_SWEEP: begin
        wr_addr_o = sweep_q;
        wr_next_o = (ix + XW'(1) < nx) ? IW'(ix + XW'(1)) : '0;
        wr_prev_o = ((ix != '0) && (ix < nx)) ? IW'(ix - XW'(1)) : '0;
        wr_tag_o  = (ix < nx) ? TAG_FREE : TAG_NONE;
        wen_o     = '{nxt: 1'b1, prv: 1'b1, tag: 1'b1};
      end
      S_EVAL: begin
        if (do_unlink) begin
          // predecessor skips the node
          wr_addr_o   = rd_prev_i;
          wr_next_o   = rd_next_i;
          wen_o.nxt   = !h_hit && ({1'b0, rd_prev_i} < POOL_X);
        end else if (op_q == MODE_PUT_FREE || op_q == MODE_PUT_TRAIN ||
                     op_q == MODE_PUT_TRACK) begin
          // old tail points to the new node
          wr_addr_o   = tails_q[lst_q];
          wr_next_o   = nd_q;
          wen_o.nxt   = (rd_tag_i == TAG_NONE) && (cnt_cur != '0) &&
                        ({1'b0, tails_q[lst_q]} < POOL_X);
        end
      end
      S_WR_PREV: begin
        wr_addr_o = q_q;
        wr_prev_o = p_q;
        wen_o.prv = pw_q;
      end
      S_WR_CLR: begin
        wr_addr_o = nd_q;
        wr_tag_o  = TAG_NONE;
        wen_o     = '{nxt: 1'b1, prv: 1'b1, tag: 1'b1};
      end
      S_WR_ND: begin
        wr_addr_o = nd_q;
        wr_prev_o = p_q;
        wr_tag_o  = lst_q;
        wen_o     = '{nxt: 1'b1, prv: 1'b1, tag: 1'b1};
      end
      default: wen_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      n_q         <= RST_N;
      init_op_q   <= 1'b0;
      op_q        <= MODE_INIT;
      nd_q        <= '0;
      lst_q       <= TAG_FREE;
      p_q         <= '0;
      q_q         <= '0;
      pw_q        <= 1'b0;
      done_q      <= 1'b0;
      node_out_q  <= '0;
      status_q    <= ST_OK;
      heads_q[0]  <= '0;
      heads_q[1]  <= '0;
      heads_q[2]  <= '0;
      tails_q[0]  <= (RST_N != '0) ? IW'(RST_N - 1'b1) : '0;
      tails_q[1]  <= '0;
      tails_q[2]  <= '0;
      counts_q[0] <= RST_N;
      counts_q[1] <= '0;
      counts_q[2] <= '0;
    end else begin
      unique case (state_q)
        S_SWEEP: begin
          sweep_q <= sweep_q + 1'b1;
          done_q  <= (sweep_q == LAST) && init_op_q;
          if (sweep_q == LAST) begin
            state_q    <= S_IDLE;
            init_op_q  <= 1'b0;
            status_q   <= ST_OK;
            node_out_q <= '0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q       <= mode_i;
            lst_q      <= req_lst;
            nd_q       <= req_take ? head_sel : IW'(node_i);
            node_out_q <= '0;
            unique case (mode_i) inside
              MODE_INIT: begin
                done_q      <= 1'b0;
                status_q    <= ST_OK;
                n_q         <= n_eff;
                sweep_q     <= '0;
                init_op_q   <= 1'b1;
                state_q     <= S_SWEEP;
                heads_q[0]  <= '0;
                heads_q[1]  <= '0;
                heads_q[2]  <= '0;
                tails_q[0]  <= (n_eff != '0) ? IW'(n_eff - 1'b1) : '0;
                tails_q[1]  <= '0;
                tails_q[2]  <= '0;
                counts_q[0] <= n_eff;
                counts_q[1] <= '0;
                counts_q[2] <= '0;
              end
              MODE_TAKE_FREE, MODE_TAKE_TRAIN, MODE_TAKE_TRACK: begin
                done_q   <= take_empty;
                status_q <= take_empty ? ST_EMPTY : ST_OK;
                if (!take_empty) begin
                  state_q <= S_EVAL;
                end
              end
              MODE_PUT_FREE, MODE_PUT_TRAIN, MODE_PUT_TRACK, MODE_QUERY_TRAIN,
              MODE_QUERY_TRACK, MODE_REMOVE_TRACK: begin
                done_q   <= !node_ok;
                status_q <= node_ok ? ST_OK : ST_NOT_FOUND;
                if (node_ok) begin
                  state_q <= S_EVAL;
                end
              end
              default: begin
                done_q   <= 1'b1;
                status_q <= ST_OK;
              end
            endcase
          end else begin
            done_q <= 1'b0;
          end
        end
        S_EVAL: begin
          if (do_unlink) begin
            done_q <= 1'b0;
            p_q    <= rd_prev_i;
            q_q    <= rd_next_i;
            pw_q   <= !t_hit && ({1'b0, rd_next_i} < POOL_X);
            counts_q[lst_q] <= cnt_dec;
            // a list that runs empty drops its head and tail
            if (cnt_dec == '0) begin
              heads_q[lst_q] <= '0;
              tails_q[lst_q] <= '0;
            end else begin
              if (h_hit) begin
                heads_q[lst_q] <= rd_next_i;
              end
              if (t_hit) begin
                tails_q[lst_q] <= rd_prev_i;
              end
            end
            state_q <= S_WR_PREV;
          end else if (op_q == MODE_QUERY_TRAIN || op_q == MODE_QUERY_TRACK) begin
            if (rd_tag_i == lst_q) begin
              node_out_q <= NODE_W'(nd_q);
            end else begin
              status_q <= ST_NOT_FOUND;
            end
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (op_q == MODE_REMOVE_TRACK || rd_tag_i != TAG_NONE) begin
            // remove of a node off the track list, or put of a node in use
            status_q <= ST_NOT_FOUND;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            done_q <= 1'b0;
            if (cnt_cur == '0) begin
              heads_q[lst_q] <= nd_q;
              p_q            <= '0;
            end else begin
              p_q <= tails_q[lst_q];
            end
            tails_q[lst_q]  <= nd_q;
            counts_q[lst_q] <= cnt_cur + 1'b1;
            state_q         <= S_WR_ND;
          end
        end
        S_WR_PREV: begin
          done_q  <= 1'b0;
          state_q <= S_WR_CLR;
        end
        S_WR_CLR: begin
          if (op_take) begin
            node_out_q <= NODE_W'(nd_q);
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_WR_ND: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign node_out_o    = node_out_q;
  assign status_o      = status_q;
  assign free_count_o  = counts_q[0];
  assign train_count_o = counts_q[1];
  assign track_count_o = counts_q[2];

endmodule

// File: rtl/node_pool_three_queue_manager_unit.sv
// channel    | handshake                  | payload
// -----------+----------------------------+--------------------------------------------
// request    | start / busy               | mode_i, node_i
// result     | done_o (one-cycle strobe)  | node_out_o, status_o, free/train/track_count_o
// config     | cfg_valid_i / cfg_ready_o  | cfg_data_i (node_count)
//
// a request is taken at a clock edge with start high and busy low; its result strobes
// straight from idle for a take on an empty list, an out-of-pool node or an unused mode,
// after S_EVAL for a query, a put of a node in use or a remove miss, after S_EVAL and
// S_WR_ND for a put, after S_EVAL, S_WR_PREV and S_WR_CLR for a take or a remove, and after
// the init sweep for init; the steps are set by the single write port of the link memory:
// one link entry per cycle. after reset a clearing pass rebuilds the free list, busy high.
// the result side cannot stall; config writes are always taken (cfg_ready_o tied high).
module node_pool_three_queue_manager_unit #(
  parameter int POOL_NODES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [npq_pkg::MODE_W-1:0] mode_i,
  input  logic [npq_pkg::NODE_W-1:0] node_i,
  output logic                       done_o,
  output logic [npq_pkg::NODE_W-1:0] node_out_o,
  output logic [npq_pkg::STAT_W-1:0] status_o,
  output logic [npq_pkg::CNT_W-1:0]  free_count_o,
  output logic [npq_pkg::CNT_W-1:0]  train_count_o,
  output logic [npq_pkg::CNT_W-1:0]  track_count_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [npq_pkg::CNT_W-1:0]  cfg_data_i
);
  import npq_pkg::*;

  // address width of the link memory
  localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;

  logic [CNT_W-1:0] node_count_q;

  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    rd_next;
  logic [IW-1:0]    rd_prev;
  logic [TAG_W-1:0] rd_tag;
  logic [IW-1:0]    wr_addr;
  npq_wen_t         wen;
  logic [IW-1:0]    wr_next;
  logic [IW-1:0]    wr_prev;
  logic [TAG_W-1:0] wr_tag;

  // node_count register: init latches it, so a write during an init sweep is harmless
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_count_q <= cfg_data_i;
    end
  end

  // next, prev and tag of every node in one memory, with a write enable per field;
  // the sequencer writes neighbors one per cycle and issues the next read only once
  // all writes of the previous request are done, so no forwarding is needed
  npq_link_ram #(
    .DEPTH (POOL_NODES),
    .AW    (IW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wen_i     (wen),
    .wr_next_i (wr_next),
    .wr_prev_i (wr_prev),
    .wr_tag_i  (wr_tag),
    .rd_next_o (rd_next),
    .rd_prev_o (rd_prev),
    .rd_tag_o  (rd_tag)
  );

  // request sequencer with list heads, tails and counts
  npq_seq #(
    .POOL_NODES (POOL_NODES),
    .IW         (IW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .node_i        (node_i),
    .node_count_i  (node_count_q),
    .done_o        (done_o),
    .node_out_o    (node_out_o),
    .status_o      (status_o),
    .free_count_o  (free_count_o),
    .train_count_o (train_count_o),
    .track_count_o (track_count_o),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_next_i     (rd_next),
    .rd_prev_i     (rd_prev),
    .rd_tag_i      (rd_tag),
    .wr_addr_o     (wr_addr),
    .wen_o         (wen),
    .wr_next_o     (wr_next),
    .wr_prev_o     (wr_prev),
    .wr_tag_o      (wr_tag)
  );

endmodule

// File: rtl/npq_checker.sv
module npq_checker #(
  parameter int POOL_NODES = 64
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [npq_pkg::MODE_W-1:0] mode_i,
  input logic [npq_pkg::NODE_W-1:0] node_i,
  input logic                       done_o,
  input logic [npq_pkg::NODE_W-1:0] node_out_o,
  input logic [npq_pkg::STAT_W-1:0] status_o,
  input logic [npq_pkg::CNT_W-1:0]  free_count_o,
  input logic [npq_pkg::CNT_W-1:0]  train_count_o,
  input logic [npq_pkg::CNT_W-1:0]  track_count_o
);
  import npq_pkg::*;

  // an in-pool query answers once its entry has been read and checked in S_EVAL
  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (mode_i == MODE_QUERY_TRAIN || mode_i == MODE_QUERY_TRACK) &&
     (32'(node_i) < POOL_NODES)) |=> ##1 done_o)
    else $error("query result missing");

  // a result only follows a taken request or work still in progress
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result without request");

  // no more nodes on the lists than the pool holds
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (int'(free_count_o) + int'(train_count_o) + int'(track_count_o) <=
                POOL_NODES))
    else $error("list counts exceed pool");

  // empty and not-found results carry no node
  a_miss_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EMPTY || status_o == ST_NOT_FOUND)) |-> (node_out_o == '0))
    else $error("node on a miss");

  // a take on an empty free list answers in the next cycle
  a_empty_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_TAKE_FREE && free_count_o == '0) |=>
    (done_o && status_o == ST_EMPTY))
    else $error("empty take not reported");

endmodule

bind node_pool_three_queue_manager_unit npq_checker #(
  .POOL_NODES (POOL_NODES)
) u_npq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .mode_i        (mode_i),
  .node_i        (node_i),
  .done_o        (done_o),
  .node_out_o    (node_out_o),
  .status_o      (status_o),
  .free_count_o  (free_count_o),
  .train_count_o (train_count_o),
  .track_count_o (track_count_o)
);
